>>> rtl/hpd_pkg.sv
// shared types, field positions and codes of the huffman prefix decoder
`timescale 1ns / 1ps

package hpd_pkg;

   // default sizes
   localparam int MAX_CODE_LEN_DEF  = 32;
   localparam int TABLE_ENTRIES_DEF = 256;

   // field widths
   localparam int SYM_W        = 8;
   localparam int BYTE_W       = 8;
   localparam int ENTRY_LEN_W  = 6;
   localparam int ENTRY_CODE_W = 32;
   localparam int FUNC_W       = 2;
   localparam int ENTRY_W      = ENTRY_LEN_W + ENTRY_CODE_W;

   // request tdata layout, lowest bit first
   localparam int DATA_BYTE_LSB  = 0;
   localparam int ENTRY_SYM_LSB  = DATA_BYTE_LSB + BYTE_W;
   localparam int ENTRY_LEN_LSB  = ENTRY_SYM_LSB + SYM_W;
   localparam int ENTRY_CODE_LSB = ENTRY_LEN_LSB + ENTRY_LEN_W;
   localparam int REQ_DATA_W     = 56;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PAD_W      = 3;
   localparam logic REG_PADDED_BITS = 1'b0;

   // count of bits handled within one byte
   localparam int BIT_CNT_W = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_DATA  = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_SCAN,
      ST_PUSH,
      ST_FLUSH
   } state_type;

endpackage

>>> rtl/hpd_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module hpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/huffman_prefix_decoder_top.sv
// huffman prefix decoder: one code bit at a time against a table held in ram
// a data byte takes per decoded bit a shift of the partial code and a scan of the table
// from the top entry down, one entry per cycle through the single compare unit, stopping
// at the first (highest) match; each result then passes the push state, and load and
// clear beats are handled in the idle state
// reset (synchronous): table emptied, partial code cleared, padded_bits 0, no beat pending
`timescale 1ns / 1ps

module huffman_prefix_decoder_top #(
   parameter int MAX_CODE_LEN  = hpd_pkg::MAX_CODE_LEN_DEF,
   parameter int TABLE_ENTRIES = hpd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // data_byte, entry_symbol, entry_length, entry_code, zero fill
   input  logic [hpd_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [hpd_pkg::FUNC_W-1:0]     req_tuser,
   // last_byte
   input  logic                           req_tlast,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // symbol
   output logic [hpd_pkg::SYM_W-1:0]      rsp_tdata,
   // overlong_error
   output logic                           rsp_tuser,
   // end_of_run
   output logic                           rsp_tlast,
   // csr port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [hpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   import hpd_pkg::*;

   localparam int IW   = $clog2(TABLE_ENTRIES);
   localparam int PW   = MAX_CODE_LEN;
   localparam int LW   = $clog2(MAX_CODE_LEN + 1);
   localparam int CMPL = (LW > ENTRY_LEN_W) ? LW : ENTRY_LEN_W;
   localparam int CW   = (PW > ENTRY_CODE_W) ? PW : ENTRY_CODE_W;
   localparam logic [IW-1:0] TOP_ADDR = IW'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [PW-1:0]            partial_ff, partial_in;
   logic [LW-1:0]            plen_ff, plen_in;
   logic [PAD_W-1:0]         padded_ff, padded_in;
   logic [BYTE_W-1:0]        byte_ff, byte_in;
   logic                     last_ff, last_in;
   logic [BIT_CNT_W-1:0]     nbits_ff, nbits_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [IW-1:0]            scan_addr_ff, scan_addr_in;
   logic [SYM_W-1:0]         res_sym_ff, res_sym_in;
   logic                     res_err_ff, res_err_in;
   logic                     hold_vld_ff, hold_vld_in;
   logic [SYM_W-1:0]         hold_sym_ff, hold_sym_in;
   logic                     hold_err_ff, hold_err_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [SYM_W-1:0]         rsp_tdata_ff, rsp_tdata_in;
   logic                     rsp_tuser_ff, rsp_tuser_in;
   logic                     rsp_tlast_ff, rsp_tlast_in;

   logic                     req_acc;
   func_type                 req_func;
   logic [SYM_W-1:0]         ld_sym;
   logic [ENTRY_LEN_W-1:0]   ld_len;
   logic [ENTRY_CODE_W-1:0]  ld_code;
   logic [ENTRY_CODE_W-1:0]  ld_code_masked;
   logic                     ld_good;
   logic                     ram_we;
   logic [ENTRY_W-1:0]       ram_rdata;
   logic [ENTRY_LEN_W-1:0]   rd_len;
   logic [ENTRY_CODE_W-1:0]  rd_code;
   logic                     scan_hit;
   logic                     overlong;
   logic                     more_bits;
   logic                     slot_free;
   logic                     csr_wr;

   assign req_acc  = req_tvalid && req_tready;
   assign req_func = func_type'(req_tuser);
   assign ld_sym   = req_tdata[ENTRY_SYM_LSB +: SYM_W];
   assign ld_len   = req_tdata[ENTRY_LEN_LSB +: ENTRY_LEN_W];
   assign ld_code  = req_tdata[ENTRY_CODE_LSB +: ENTRY_CODE_W];

   // code bits at or above the length are dropped on load
   always_comb begin
      for (int i = 0; i < ENTRY_CODE_W; i++) begin
         ld_code_masked[i] = ld_code[i] && (ENTRY_LEN_W'(i) < ld_len);
      end
   end

   assign ld_good = ({1'b0, ld_sym} < (SYM_W + 1)'(TABLE_ENTRIES)) && (ld_len != '0) &&
                    ((ENTRY_LEN_W + 2)'(ld_len) <= (ENTRY_LEN_W + 2)'(MAX_CODE_LEN));

   assign ram_we = (state_ff == ST_IDLE) && req_acc && (req_func == FUNC_LOAD) && ld_good;

   hpd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ld_sym[IW-1:0]),
      .wr_data ({ld_len, ld_code_masked}),
      .rd_addr (scan_addr_in),
      .rd_data (ram_rdata)
   );

   // read address is fed the next scan address so the data lines up with scan_addr_ff
   assign rd_len  = ram_rdata[ENTRY_CODE_W +: ENTRY_LEN_W];
   assign rd_code = ram_rdata[ENTRY_CODE_W-1:0];

   assign scan_hit  = (state_ff == ST_SCAN) && valid_ff[scan_addr_ff] &&
                      (CMPL'(rd_len) == CMPL'(plen_ff)) &&
                      (CW'(rd_code) == CW'(partial_ff));
   assign overlong  = (plen_ff >= LW'(MAX_CODE_LEN));
   assign more_bits = (bit_cnt_ff != nbits_ff);
   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);

   // csr
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PADDED_BITS) ? CSR_DATA_W'(padded_ff) : '0;
   assign padded_in  = (csr_wr && (csr_paddr[2] == REG_PADDED_BITS)) ?
                       csr_pwdata[PAD_W-1:0] : padded_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_func == FUNC_DATA)) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_PUSH;
            end else if (scan_addr_ff == '0) begin
               if (overlong) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = more_bits ? ST_BIT : ST_FLUSH;
               end
            end
         end
         ST_PUSH: begin
            if (!hold_vld_ff || slot_free) begin
               state_in = more_bits ? ST_BIT : ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!hold_vld_ff || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      valid_in      = valid_ff;
      partial_in    = partial_ff;
      plen_in       = plen_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      nbits_in      = nbits_ff;
      bit_cnt_in    = bit_cnt_ff;
      scan_addr_in  = scan_addr_ff;
      res_sym_in    = res_sym_ff;
      res_err_in    = res_err_ff;
      hold_vld_in   = hold_vld_ff;
      hold_sym_in   = hold_sym_ff;
      hold_err_in   = hold_err_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_func)
                  FUNC_DATA: begin
                     byte_in    = req_tdata[DATA_BYTE_LSB +: BYTE_W];
                     last_in    = req_tlast;
                     nbits_in   = req_tlast ? (BIT_CNT_W'(BYTE_W) - BIT_CNT_W'(padded_ff)) :
                                              BIT_CNT_W'(BYTE_W);
                     bit_cnt_in = '0;
                  end
                  FUNC_LOAD: begin
                     if (ld_good) begin
                        valid_in[ld_sym[IW-1:0]] = 1'b1;
                     end
                  end
                  FUNC_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BIT: begin
            partial_in   = PW'({partial_ff, byte_ff[BYTE_W-1]});
            plen_in      = plen_ff + 1'b1;
            byte_in      = {byte_ff[BYTE_W-2:0], 1'b0};
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            scan_addr_in = TOP_ADDR;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               res_sym_in = SYM_W'(scan_addr_ff);
               res_err_in = 1'b0;
               partial_in = '0;
               plen_in    = '0;
            end else if (scan_addr_ff == '0) begin
               if (overlong) begin
                  res_sym_in = '0;
                  res_err_in = 1'b1;
                  partial_in = '0;
                  plen_in    = '0;
               end
            end else begin
               scan_addr_in = scan_addr_ff - 1'b1;
            end
         end
         ST_PUSH: begin
            // the held result goes out only once a later one shows it is not the last
            if (!hold_vld_ff || slot_free) begin
               if (hold_vld_ff) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = hold_sym_ff;
                  rsp_tuser_in  = hold_err_ff;
                  rsp_tlast_in  = 1'b0;
               end
               hold_vld_in = 1'b1;
               hold_sym_in = res_sym_ff;
               hold_err_in = res_err_ff;
            end
         end
         ST_FLUSH: begin
            if (last_ff) begin
               partial_in = '0;
               plen_in    = '0;
            end
            if (hold_vld_ff && slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = hold_sym_ff;
               rsp_tuser_in  = hold_err_ff;
               rsp_tlast_in  = 1'b1;
               hold_vld_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         partial_ff    <= '0;
         plen_ff       <= '0;
         padded_ff     <= '0;
         hold_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         partial_ff    <= partial_in;
         plen_ff       <= plen_in;
         padded_ff     <= padded_in;
         hold_vld_ff   <= hold_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      nbits_ff     <= nbits_in;
      bit_cnt_ff   <= bit_cnt_in;
      scan_addr_ff <= scan_addr_in;
      res_sym_ff   <= res_sym_in;
      res_err_ff   <= res_err_in;
      hold_sym_ff  <= hold_sym_in;
      hold_err_ff  <= hold_err_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // no held result may remain once the block takes a new beat
   a_hold_flushed : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !hold_vld_ff)
      else $error("held result left over while idle");

   // the partial code never grows past the longest code
   a_plen_bound : assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LW'(MAX_CODE_LEN))
      else $error("partial code length out of range");

   // a scan always follows a freshly appended bit
   a_scan_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (plen_ff != '0))
      else $error("table scan with empty partial code");

   // a clear beat empties the whole table
   a_clear_table : assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_func == FUNC_CLEAR)) |=> (valid_ff == '0))
      else $error("table not empty after clear");

endmodule
